// ===== hdl/scba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_pkg
// Shared widths, status codes and stage control word for the size class
// block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

  // Fixed field widths of the request and response words
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned GSIZE_W  = 11;
  localparam int unsigned STATUS_W = 2;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // Request kinds
  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  // Control word handed from the stack stage to the result stage
  typedef struct packed {
    logic    is_free;
    status_t status;
    logic    use_reset;   // popped entry never written since reset
  } ctl_t;

endpackage

// ===== hdl/scba_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_req_if
// Request channel: valid/ready handshake carrying one allocate or free word.
// ----------------------------------------------------------------------------
interface scba_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [scba_pkg::SIZE_W-1:0]      req_size;
  logic [scba_pkg::ADDR_W-1:0]      block_address;

  modport source (output valid, req_type, req_size, block_address, input ready);
  modport sink   (input valid, req_type, req_size, block_address, output ready);
endinterface

// ===== hdl/scba_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface scba_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [scba_pkg::STATUS_W-1:0]    status;
  logic [scba_pkg::ADDR_W-1:0]      granted_address;
  logic [scba_pkg::GSIZE_W-1:0]     granted_size;

  modport source (output valid, status, granted_address, granted_size, input ready);
  modport sink   (input valid, status, granted_address, granted_size, output ready);
endinterface

// ===== hdl/scba_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_stack
// Per-class free stacks: fill counters, low-water marks and the slot memory.
// Decides the status of each word and performs its push or pop.
// ----------------------------------------------------------------------------
module scba_stack #(
  parameter int CLASS_COUNT     = 4,
  parameter int PAGE_BYTES      = 1024,
  parameter int MIN_BLOCK_BYTES = 128
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // from the input register
  input  logic                                   in_valid,
  input  logic                                   in_free,
  input  logic                                   in_big,
  input  logic [((CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1)-1:0] in_cls,
  input  logic [scba_pkg::ADDR_W-1:0]            in_rel,
  output logic                                   take,
  // to the result stage
  input  logic                                   out_take,
  output logic                                   m_valid,
  output scba_pkg::ctl_t                         m_ctl,
  output logic [((CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1)-1:0] m_cls,
  output logic [(((PAGE_BYTES >> $clog2(MIN_BLOCK_BYTES)) > 1) ?
                 $clog2(PAGE_BYTES >> $clog2(MIN_BLOCK_BYTES)) : 1)-1:0] m_slot,
  output logic [(((PAGE_BYTES >> $clog2(MIN_BLOCK_BYTES)) > 1) ?
                 $clog2(PAGE_BYTES >> $clog2(MIN_BLOCK_BYTES)) : 1)-1:0] m_rst_slot
);

  localparam int MIN_LOG     = $clog2(MIN_BLOCK_BYTES);
  localparam int SLOTS_MAX   = PAGE_BYTES >> MIN_LOG;
  localparam int SLOTS_DEPTH = (SLOTS_MAX > 0) ? SLOTS_MAX : 1;
  localparam int SLOT_W      = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;
  localparam int CNT_W       = (SLOTS_MAX > 0) ? $clog2(SLOTS_MAX + 1) : 1;
  localparam int CLS_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int AW          = scba_pkg::ADDR_W;

  // Slots in the page of one class
  function automatic logic [CNT_W-1:0] slots_of(input logic [CLS_W-1:0] c);
    return CNT_W'(PAGE_BYTES >> (MIN_LOG + int'(c)));
  endfunction

  // Bytes covered by the slots of one class
  function automatic logic [AW-1:0] span_of(input logic [CLS_W-1:0] c);
    return AW'((PAGE_BYTES >> (MIN_LOG + int'(c))) << (MIN_LOG + int'(c)));
  endfunction

  logic [CNT_W-1:0]  count     [CLASS_COUNT];
  logic [CNT_W-1:0]  low_mark  [CLASS_COUNT];
  logic [SLOT_W-1:0] stack_mem [CLASS_COUNT][SLOTS_DEPTH];

  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  lw;
  logic [CNT_W-1:0]  pop_idx;
  logic [AW-1:0]     offset;
  logic [SLOT_W-1:0] push_slot;
  logic              pop_ok;
  logic              push_ok;
  logic              fire;
  scba_pkg::status_t status;

  // Look up the class state and decide the outcome
  always_comb begin
    n         = slots_of(in_cls);
    cnt       = count[in_cls];
    lw        = low_mark[in_cls];
    pop_idx   = cnt - CNT_W'(1);
    offset    = in_rel - AW'(int'(in_cls) * PAGE_BYTES);
    push_slot = SLOT_W'(offset >> (MIN_LOG + int'(in_cls)));
    pop_ok    = !in_free && !in_big && (cnt != '0);
    push_ok   = in_free && !in_big && (cnt < n) && (offset < span_of(in_cls));
    priority if (in_big) begin
      status = scba_pkg::ST_TOO_LARGE;
    end else if (!in_free) begin
      status = pop_ok ? scba_pkg::ST_OK : scba_pkg::ST_EMPTY;
    end else begin
      status = push_ok ? scba_pkg::ST_OK : scba_pkg::ST_OVERFLOW;
    end
  end

  // Advance when the result stage is free or moving
  assign take = !m_valid || out_take;
  assign fire = take && in_valid;

  // Counters and low-water marks; reset refills every class at once
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      for (int c = 0; c < CLASS_COUNT; c++) begin
        count[c]    <= slots_of(CLS_W'(c));
        low_mark[c] <= slots_of(CLS_W'(c));
      end
    end else begin
      if (take) begin
        m_valid <= in_valid;
      end
      if (fire && pop_ok) begin
        count[in_cls] <= pop_idx;
        if (pop_idx < lw) begin
          low_mark[in_cls] <= pop_idx;
        end
      end
      if (fire && push_ok) begin
        count[in_cls] <= cnt + CNT_W'(1);
      end
    end
  end

  // Slot memory: push writes on top, pop reads the top entry
  always_ff @(posedge clk) begin
    if (fire && push_ok) begin
      stack_mem[in_cls][cnt[SLOT_W-1:0]] <= push_slot;
    end
    if (take) begin
      m_slot <= stack_mem[in_cls][pop_idx[SLOT_W-1:0]];
    end
  end

  // Hold the word's control and the reset-time slot for entries below the mark
  always_ff @(posedge clk) begin
    if (take) begin
      m_ctl.is_free   <= in_free;
      m_ctl.status    <= status;
      m_ctl.use_reset <= pop_idx < lw;
      m_cls           <= in_cls;
      m_rst_slot      <= SLOT_W'(n - CNT_W'(1) - pop_idx);
    end
  end

endmodule

// ===== hdl/scba_result.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_result
// Result stage: forms the granted address and size and holds the response
// word until it is taken.
// ----------------------------------------------------------------------------
module scba_result #(
  parameter int CLASS_COUNT     = 4,
  parameter int PAGE_BYTES      = 1024,
  parameter int MIN_BLOCK_BYTES = 128
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   m_valid,
  input  scba_pkg::ctl_t                         m_ctl,
  input  logic [((CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1)-1:0] m_cls,
  input  logic [(((PAGE_BYTES >> $clog2(MIN_BLOCK_BYTES)) > 1) ?
                 $clog2(PAGE_BYTES >> $clog2(MIN_BLOCK_BYTES)) : 1)-1:0] m_slot,
  input  logic [(((PAGE_BYTES >> $clog2(MIN_BLOCK_BYTES)) > 1) ?
                 $clog2(PAGE_BYTES >> $clog2(MIN_BLOCK_BYTES)) : 1)-1:0] m_rst_slot,
  input  logic [scba_pkg::ADDR_W-1:0]            pool_base,
  output logic                                   out_take,
  scba_rsp_if.source                             rsp
);

  localparam int MIN_LOG   = $clog2(MIN_BLOCK_BYTES);
  localparam int SLOTS_MAX = PAGE_BYTES >> MIN_LOG;
  localparam int SLOT_W    = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;
  localparam int AW        = scba_pkg::ADDR_W;
  localparam int GSW       = scba_pkg::GSIZE_W;

  logic [SLOT_W-1:0] slot;
  logic [AW-1:0]     page_off;
  logic              ok;

  // Pick the slot and place it inside the class page
  always_comb begin
    slot     = m_ctl.use_reset ? m_rst_slot : m_slot;
    page_off = AW'(int'(m_cls) * PAGE_BYTES) + (AW'(slot) << (MIN_LOG + int'(m_cls)));
    ok       = m_ctl.status == scba_pkg::ST_OK;
  end

  assign out_take = !rsp.valid || rsp.ready;

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_take) begin
      rsp.valid <= m_valid;
    end
  end

  // Output word; zero address on frees and errors, zero size on errors
  always_ff @(posedge clk) begin
    if (out_take) begin
      rsp.status          <= m_ctl.status;
      rsp.granted_address <= (ok && !m_ctl.is_free) ? pool_base + page_off : '0;
      rsp.granted_size    <= ok ? GSW'(MIN_BLOCK_BYTES << int'(m_cls)) : '0;
    end
  end

endmodule

// ===== hdl/size_class_block_allocator.sv =====
`timescale 1ns / 1ps
// Pipeline: a response word passes the input register, then the stack stage,
// then the result register. Throughput: one request per cycle while the
// response side does not stall; each word does at most one push or pop on
// the per-class stack memory, and the next word sees the updated counter.
// Reset: synchronous; all classes come back full at once through the fill
// counters and low-water marks, so no clearing pass is run.
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Block allocator over power-of-two size classes, each owning one page and a
// LIFO stack of free slots.
// ----------------------------------------------------------------------------
module size_class_block_allocator #(
  parameter int CLASS_COUNT     = 4,
  parameter int PAGE_BYTES      = 1024,
  parameter int MIN_BLOCK_BYTES = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [scba_pkg::ADDR_W-1:0] cfg_wdata,
  scba_req_if.sink                   req,
  scba_rsp_if.source                 rsp
);

  localparam int MIN_LOG   = $clog2(MIN_BLOCK_BYTES);
  localparam int SLOTS_MAX = PAGE_BYTES >> MIN_LOG;
  localparam int SLOT_W    = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;
  localparam int CLS_W     = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int AW        = scba_pkg::ADDR_W;

  logic [AW-1:0]     pool_base;
  logic [CLS_W-1:0]  pick_cls;
  logic              pick_big;

  logic              i_v;
  logic              i_free;
  logic              i_big;
  logic [CLS_W-1:0]  i_cls;
  logic [AW-1:0]     i_rel;
  logic              in_take;

  logic              mid_take;
  logic              m_valid;
  scba_pkg::ctl_t    m_ctl;
  logic [CLS_W-1:0]  m_cls;
  logic [SLOT_W-1:0] m_slot;
  logic [SLOT_W-1:0] m_rst_slot;
  logic              out_take;

  // Pool base register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_we) begin
      pool_base <= cfg_wdata;
    end
  end

  // Smallest class that fits the size, rounding up
  always_comb begin
    pick_cls = '0;
    pick_big = 1'b1;
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if (AW'(req.req_size) <= (AW'(MIN_BLOCK_BYTES) << c)) begin
        pick_cls = CLS_W'(c);
        pick_big = 1'b0;
      end
    end
  end

  assign in_take   = !i_v || mid_take;
  assign req.ready = in_take;

  // Input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
    end else if (in_take) begin
      i_v <= req.valid;
    end
  end

  // Input register word; keep the address relative to the pool
  always_ff @(posedge clk) begin
    if (in_take) begin
      i_free <= req.req_type == scba_pkg::REQ_FREE;
      i_big  <= pick_big;
      i_cls  <= pick_cls;
      i_rel  <= req.block_address - pool_base;
    end
  end

  scba_stack #(
    .CLASS_COUNT     (CLASS_COUNT),
    .PAGE_BYTES      (PAGE_BYTES),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_stack (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (i_v),
    .in_free    (i_free),
    .in_big     (i_big),
    .in_cls     (i_cls),
    .in_rel     (i_rel),
    .take       (mid_take),
    .out_take   (out_take),
    .m_valid    (m_valid),
    .m_ctl      (m_ctl),
    .m_cls      (m_cls),
    .m_slot     (m_slot),
    .m_rst_slot (m_rst_slot)
  );

  scba_result #(
    .CLASS_COUNT     (CLASS_COUNT),
    .PAGE_BYTES      (PAGE_BYTES),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_result (
    .clk        (clk),
    .rst        (rst),
    .m_valid    (m_valid),
    .m_ctl      (m_ctl),
    .m_cls      (m_cls),
    .m_slot     (m_slot),
    .m_rst_slot (m_rst_slot),
    .pool_base  (pool_base),
    .out_take   (out_take),
    .rsp        (rsp)
  );

endmodule

// ===== hdl/scba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_checker
// Port-level checks on the allocator's response channel, bound to the top.
// ----------------------------------------------------------------------------
module scba_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [scba_pkg::STATUS_W-1:0] status,
  input logic [scba_pkg::ADDR_W-1:0]   granted_address,
  input logic [scba_pkg::GSIZE_W-1:0]  granted_size
);

  // No response straight out of reset
  a_reset_clean: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  // Errors carry neither address nor size
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != scba_pkg::ST_OK) |->
      (granted_address == '0) && (granted_size == '0))
    else $error("error response with nonzero address or size");

  // A served size is zero or a single power of two
  a_size_class: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == scba_pkg::ST_OK) |-> $onehot0(granted_size))
    else $error("granted size is not a class size");

  // A stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(granted_address) && $stable(granted_size))
    else $error("stalled response word changed");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .status          (rsp.status),
  .granted_address (rsp.granted_address),
  .granted_size    (rsp.granted_size)
);

// ===== verif/tb_size_class_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_class_block_allocator
// Self-checking bench for the size class block allocator. A directed table
// covers the size and address extremes and every status code. Random
// allocate and free traffic then runs under several pool bases. Every
// response word is checked against its table entry or an in-bench model of
// the per-class free stacks, with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb_size_class_block_allocator;

  localparam int unsigned CLASSES    = 4;
  localparam int unsigned PAGE       = 1024;
  localparam int unsigned MIN_BLK    = 128;
  localparam int unsigned DIR_ROWS   = 23;
  localparam int unsigned PHASES     = 5;
  localparam int unsigned PHASE_REQS = 400;
  localparam int unsigned RUN_LIMIT  = 400000;

  typedef struct packed {
    scba_pkg::status_t              status;
    logic [scba_pkg::ADDR_W-1:0]    granted_address;
    logic [scba_pkg::GSIZE_W-1:0]   granted_size;
  } grant_word_t;

  typedef struct packed {
    logic                           typed;
    scba_pkg::req_kind_t            kind;
    logic [scba_pkg::SIZE_W-1:0]    size;
    logic [scba_pkg::ADDR_W-1:0]    addr;
    scba_pkg::status_t              status;
    logic [scba_pkg::ADDR_W-1:0]    granted_address;
    logic [scba_pkg::GSIZE_W-1:0]   granted_size;
  } dir_row_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [2:0] slot;
  } held_blk_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [scba_pkg::ADDR_W-1:0] cfg_wdata;

  scba_req_if req_ch ();
  scba_rsp_if rsp_ch ();

  size_class_block_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Model state: pool base, per-class free stacks and fill levels
  logic [scba_pkg::ADDR_W-1:0] pool_base_q;
  logic [2:0]                  slot_stack [CLASSES][PAGE/MIN_BLK];
  int unsigned                 free_cnt [CLASSES];

  grant_word_t expected_grants [$];
  held_blk_t   held_blocks [$];
  held_blk_t   freed_recent [$];
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned burst_left;

  // Directed table: typed rows are obvious from reset state, others predicted
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b1, scba_pkg::REQ_ALLOC, 16'd0,    32'h0000_0000, scba_pkg::ST_OK, 32'd0, 11'd128},
    '{1'b1, scba_pkg::REQ_ALLOC, 16'd128,  32'h0000_0000, scba_pkg::ST_OK, 32'd128, 11'd128},
    '{1'b1, scba_pkg::REQ_ALLOC, 16'd129,  32'h0000_0000, scba_pkg::ST_OK, 32'd1024, 11'd256},
    '{1'b1, scba_pkg::REQ_ALLOC, 16'd1024, 32'hFFFF_FFFF, scba_pkg::ST_OK, 32'd3072, 11'd1024},
    '{1'b1, scba_pkg::REQ_ALLOC, 16'd1024, 32'h0000_0000, scba_pkg::ST_EMPTY, 32'd0, 11'd0},
    '{1'b1, scba_pkg::REQ_ALLOC, 16'd1025, 32'h0000_0000, scba_pkg::ST_TOO_LARGE, 32'd0, 11'd0},
    '{1'b1, scba_pkg::REQ_ALLOC, 16'hFFFF, 32'h0000_0000, scba_pkg::ST_TOO_LARGE, 32'd0, 11'd0},
    '{1'b1, scba_pkg::REQ_FREE,  16'd1024, 32'd3072,      scba_pkg::ST_OK, 32'd0, 11'd1024},
    '{1'b1, scba_pkg::REQ_FREE,  16'd1024, 32'd3072,      scba_pkg::ST_OVERFLOW, 32'd0, 11'd0},
    '{1'b1, scba_pkg::REQ_FREE,  16'hFFFF, 32'hFFFF_FFFF, scba_pkg::ST_TOO_LARGE, 32'd0, 11'd0},
    '{1'b1, scba_pkg::REQ_FREE,  16'd128,  32'hFFFF_FFFF, scba_pkg::ST_OVERFLOW, 32'd0, 11'd0},
    '{1'b1, scba_pkg::REQ_FREE,  16'd256,  32'h0000_0000, scba_pkg::ST_OVERFLOW, 32'd0, 11'd0},
    '{1'b1, scba_pkg::REQ_FREE,  16'd128,  32'd130,       scba_pkg::ST_OK, 32'd0, 11'd128},
    '{1'b0, scba_pkg::REQ_ALLOC, 16'd100,  32'h0000_0000, scba_pkg::ST_OK, 32'd0, 11'd0},
    '{1'b1, scba_pkg::REQ_FREE,  16'd512,  32'd2148,      scba_pkg::ST_OVERFLOW, 32'd0, 11'd0},
    '{1'b1, scba_pkg::REQ_ALLOC, 16'd512,  32'h0000_0000, scba_pkg::ST_OK, 32'd2048, 11'd512},
    '{1'b1, scba_pkg::REQ_ALLOC, 16'd300,  32'h0000_0000, scba_pkg::ST_OK, 32'd2560, 11'd512},
    '{1'b1, scba_pkg::REQ_ALLOC, 16'd257,  32'h0000_0000, scba_pkg::ST_EMPTY, 32'd0, 11'd0},
    '{1'b1, scba_pkg::REQ_FREE,  16'd400,  32'd2560,      scba_pkg::ST_OK, 32'd0, 11'd512},
    '{1'b0, scba_pkg::REQ_FREE,  16'd512,  32'd2560,      scba_pkg::ST_OK, 32'd0, 11'd0},
    '{1'b0, scba_pkg::REQ_ALLOC, 16'd512,  32'h0000_0000, scba_pkg::ST_OK, 32'd0, 11'd0},
    '{1'b0, scba_pkg::REQ_ALLOC, 16'd511,  32'h0000_0000, scba_pkg::ST_OK, 32'd0, 11'd0},
    '{1'b0, scba_pkg::REQ_ALLOC, 16'd256,  32'h0000_0000, scba_pkg::ST_OK, 32'd0, 11'd0}
  };

  // Smallest class whose block holds the size; CLASSES when none does
  function automatic int unsigned size_class(logic [scba_pkg::SIZE_W-1:0] size);
    int unsigned c;
    for (c = 0; c < CLASSES; c++) begin
      if (32'(size) <= (MIN_BLK << c)) return c;
    end
    return CLASSES;
  endfunction

  // Refill every class, slot zero on top
  function automatic void refill_stacks();
    int unsigned c;
    int unsigned i;
    int unsigned n;
    for (c = 0; c < CLASSES; c++) begin
      n = PAGE / (MIN_BLK << c);
      for (i = 0; i < n; i++) slot_stack[c][i] = 3'(n - 1 - i);
      free_cnt[c] = n;
    end
  endfunction

  // Apply one request to the model and return the response it should give
  function automatic grant_word_t grant_predict(scba_pkg::req_kind_t kind,
                                                logic [scba_pkg::SIZE_W-1:0] size,
                                                logic [scba_pkg::ADDR_W-1:0] addr);
    grant_word_t r;
    int unsigned c;
    int unsigned nslots;
    logic [31:0] bytes;
    logic [31:0] page;
    logic [31:0] offset;
    r = '{scba_pkg::ST_OK, 32'd0, 11'd0};
    c = size_class(size);
    if (c >= CLASSES) begin
      r.status = scba_pkg::ST_TOO_LARGE;
    end else begin
      bytes  = MIN_BLK << c;
      nslots = PAGE / bytes;
      page   = pool_base_q + c * PAGE;
      if (kind == scba_pkg::REQ_ALLOC) begin
        if (free_cnt[c] == 0) begin
          r.status = scba_pkg::ST_EMPTY;
        end else begin
          free_cnt[c]--;
          r.granted_address = page + 32'(slot_stack[c][free_cnt[c]]) * bytes;
          r.granted_size    = bytes[scba_pkg::GSIZE_W-1:0];
        end
      end else begin
        offset = addr - page;
        if (free_cnt[c] >= nslots || offset >= nslots * bytes) begin
          r.status = scba_pkg::ST_OVERFLOW;
        end else begin
          slot_stack[c][free_cnt[c]] = 3'(offset / bytes);
          free_cnt[c]++;
          r.granted_size = bytes[scba_pkg::GSIZE_W-1:0];
        end
      end
    end
    return r;
  endfunction

  // Size that maps to class c, leaning on the class boundaries
  function automatic logic [scba_pkg::SIZE_W-1:0] pick_size_in_class(int unsigned c);
    int unsigned lo;
    int unsigned hi;
    lo = (c == 0) ? 0 : (MIN_BLK << (c - 1)) + 1;
    hi = MIN_BLK << c;
    case ($urandom_range(0, 7))
      0, 1:    return scba_pkg::SIZE_W'(hi);
      2:       return scba_pkg::SIZE_W'(lo);
      default: return scba_pkg::SIZE_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // Offer one request word in bursts; model it once it is taken
  task automatic send_word(input scba_pkg::req_kind_t kind,
                           input logic [scba_pkg::SIZE_W-1:0] size,
                           input logic [scba_pkg::ADDR_W-1:0] addr, input logic typed,
                           input grant_word_t typed_word);
    int unsigned gap;
    int unsigned c;
    grant_word_t got;
    held_blk_t hb;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= kind;
    req_ch.req_size      <= size;
    req_ch.block_address <= addr;
    do @(posedge clk); while (!req_ch.ready);
    got = grant_predict(kind, size, addr);
    expected_grants.push_back(typed ? typed_word : got);
    // Track granted blocks so that later frees hit live slots
    if (kind == scba_pkg::REQ_ALLOC && got.status == scba_pkg::ST_OK) begin
      c       = size_class(size);
      hb.cls  = 2'(c);
      hb.slot = 3'((got.granted_address - pool_base_q - c * PAGE) >> (7 + c));
      held_blocks.push_back(hb);
    end
  endtask

  // Mostly well-formed allocate/free traffic, some noise and broken frees
  task automatic pick_random_word(output scba_pkg::req_kind_t kind,
                                  output logic [scba_pkg::SIZE_W-1:0] size,
                                  output logic [scba_pkg::ADDR_W-1:0] addr);
    int unsigned roll;
    int unsigned c;
    int unsigned idx;
    logic [31:0] bytes;
    held_blk_t hb;
    roll = $urandom_range(0, 99);
    c    = $urandom_range(0, CLASSES - 1);
    addr = $urandom;
    if (roll < 45 || (roll < 80 && held_blocks.size() == 0)) begin
      kind = scba_pkg::REQ_ALLOC;
      size = pick_size_in_class(c);
    end else if (roll < 80) begin
      idx = $urandom_range(0, held_blocks.size() - 1);
      hb  = held_blocks[idx];
      held_blocks.delete(idx);
      freed_recent.push_back(hb);
      if (freed_recent.size() > 8) void'(freed_recent.pop_front());
      kind  = scba_pkg::REQ_FREE;
      bytes = MIN_BLK << hb.cls;
      size  = pick_size_in_class(hb.cls);
      addr  = pool_base_q + 32'(hb.cls) * PAGE + 32'(hb.slot) * bytes;
      if ($urandom_range(0, 7) == 0) addr += $urandom_range(1, bytes - 1);
    end else begin
      kind = scba_pkg::req_kind_t'($urandom_range(0, 1));
      case ($urandom_range(0, 2))
        0:       size = scba_pkg::SIZE_W'($urandom);
        1:       size = scba_pkg::SIZE_W'((MIN_BLK << c) + $urandom_range(0, 1));
        default: size = pick_size_in_class(c);
      endcase
      case ($urandom_range(0, 3))
        0: addr = $urandom;
        1: begin
          // Free again a block released a short while ago
          if (freed_recent.size() > 0) begin
            hb   = freed_recent[$urandom_range(0, freed_recent.size() - 1)];
            size = pick_size_in_class(hb.cls);
            addr = pool_base_q + 32'(hb.cls) * PAGE + 32'(hb.slot) * (MIN_BLK << hb.cls);
          end
        end
        2: addr = pool_base_q + c * PAGE + $urandom_range(0, PAGE - 1);
        default: begin
          if ($urandom_range(0, 1) == 0) addr = pool_base_q + c * PAGE - $urandom_range(1, 64);
          else addr = pool_base_q + (c + 1) * PAGE + $urandom_range(0, 64);
        end
      endcase
    end
  endtask

  // Write the pool base once every response is home
  task automatic write_pool_base(input logic [scba_pkg::ADDR_W-1:0] value);
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we      <= 1'b0;
    pool_base_q  = value;
    @(posedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Response side: mixed stall patterns and one long hold-off
  initial begin : rsp_stall_gen
    int unsigned seg;
    int unsigned mode;
    rsp_ch.ready <= 1'b0;
    seg = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (seg == 6) begin
        repeat (300) begin
          rsp_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        mode = $urandom_range(0, 2);
        repeat (48) begin
          case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  // Check each response word against the oldest expectation
  always @(posedge clk) begin : grant_check
    grant_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected response word: status %0d address %h size %0d",
               rsp_ch.status, rsp_ch.granted_address, rsp_ch.granted_size);
        err_count++;
      end else begin
        want = expected_grants.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          err_count++;
        end
        if (rsp_ch.granted_address !== want.granted_address) begin
          $error("granted_address: expected %h, got %h",
                 want.granted_address, rsp_ch.granted_address);
          err_count++;
        end
        if (rsp_ch.granted_size !== want.granted_size) begin
          $error("granted_size: expected %0d, got %0d",
                 want.granted_size, rsp_ch.granted_size);
          err_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases per pool base
  initial begin : main_seq
    logic [scba_pkg::ADDR_W-1:0] bases [PHASES];
    int unsigned p;
    int unsigned i;
    scba_pkg::req_kind_t kind;
    logic [scba_pkg::SIZE_W-1:0] size;
    logic [scba_pkg::ADDR_W-1:0] addr;
    err_count  = 0;
    burst_left = 0;
    pool_base_q = '0;
    refill_stacks();
    bases = '{32'hFFFF_FFFF, 32'h0000_0000, 32'($urandom), 32'hFFFF_F800, 32'h8000_0000};
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= scba_pkg::REQ_ALLOC;
    req_ch.req_size      <= '0;
    req_ch.block_address <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under the reset pool base
    for (i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_rows[i].kind, dir_rows[i].size, dir_rows[i].addr, dir_rows[i].typed,
                '{dir_rows[i].status, dir_rows[i].granted_address,
                  dir_rows[i].granted_size});
    end
    req_ch.valid <= 1'b0;

    // Random traffic, one phase per pool base
    for (p = 0; p < PHASES; p++) begin
      write_pool_base(bases[p]);
      for (i = 0; i < PHASE_REQS; i++) begin
        pick_random_word(kind, size, addr);
        send_word(kind, size, addr, 1'b0, '0);
      end
      req_ch.valid <= 1'b0;
    end

    // Drain, then let the pipeline settle
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/scba_pkg.sv
hdl/scba_req_if.sv
hdl/scba_rsp_if.sv
hdl/scba_stack.sv
hdl/scba_result.sv
hdl/size_class_block_allocator.sv
hdl/scba_checker.sv
verif/tb_size_class_block_allocator.sv
